// File: rtl/core/linear_interp_audio_resampler_macros.svh
// Assertion macros for the linear interpolation resampler.
// Included by the top level only; no other dependencies.
`ifndef LINEAR_INTERP_AUDIO_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_AUDIO_RESAMPLER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LIRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lirs assertion failed");

// next-cycle implication, disabled while in reset
`define LIRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lirs assertion failed");

`endif

// File: rtl/core/lirs_pkg.sv
// Shared constants for the linear interpolation resampler.
// No dependencies; imported by lirs_lerp_unit and the top level.
`default_nettype none

package lirs_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int RATIO_W         = 21;
    localparam int PHASE_FB_DEF    = 16;
    localparam int MAX_OUT_DEF     = 16;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [RATIO_W-1:0] RATIO_RESET  = RATIO_W'(65536);
    localparam logic               STEREO_RESET = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_RATIO  = 1'b0;
    localparam logic REG_STEREO = 1'b1;

endpackage

`default_nettype wire

// File: rtl/core/lirs_lerp_unit.sv
// Shared interpolation unit: one signed multiply per call, registered,
// then truncating scale and add onto the base sample. Uses lirs_pkg.
`default_nettype none

module lirs_lerp_unit
    import lirs_pkg::*;
#(
    parameter int FB = PHASE_FB_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_en,
    input  wire  signed [SAMPLE_W-1:0] i_prev,
    input  wire  signed [SAMPLE_W-1:0] i_cur,
    input  wire         [FB-1:0]       i_frac,
    output logic signed [SAMPLE_W-1:0] o_res
);

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FB + 1;
    localparam logic signed [PROD_W-1:0] BIAS = {{(PROD_W-FB){1'b0}}, {FB{1'b1}}};

    logic signed [DIFF_W-1:0]   diff;
    logic signed [FB:0]         frac_s;
    logic signed [PROD_W-1:0]   prod_c;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_base;
    logic signed [PROD_W-1:0]   biased;
    logic signed [PROD_W-1:0]   shifted;
    logic signed [DIFF_W-1:0]   sum;

    assign diff   = DIFF_W'(i_cur) - DIFF_W'(i_prev);
    assign frac_s = $signed({1'b0, i_frac});
    assign prod_c = PROD_W'(diff) * PROD_W'(frac_s);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= prod_c;
            r_base <= i_prev;
        end
    end

    // divide by 2^FB rounding toward zero
    assign biased  = r_prod + (r_prod[PROD_W-1] ? BIAS : '0);
    assign shifted = biased >>> FB;
    assign sum     = DIFF_W'(r_base) + shifted[DIFF_W-1:0];
    assign o_res   = sum[SAMPLE_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/linear_interp_audio_resampler.sv
// Linear interpolation sample rate converter. An input frame is taken while
// idle; each result then passes through the single shared multiplier in steps
// (left product, right product, load into the output register), and a frame
// yields n results (n at most MAX_OUTPUTS_PER_INPUT); the load step waits while
// the output side stalls. The priming frame and frames falling in a downsampling
// gap yield no result. s_tready is high only between frames; the output
// register lets the last result of a frame wait while the next frame enters.
// Depends on lirs_pkg, lirs_lerp_unit and the macros header.
`default_nettype none

`include "linear_interp_audio_resampler_macros.svh"

module linear_interp_audio_resampler
    import lirs_pkg::*;
#(
    parameter int PHASE_FRACTION_BITS   = PHASE_FB_DEF,
    parameter int MAX_OUTPUTS_PER_INPUT = MAX_OUT_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // input stream
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [2*SAMPLE_W-1:0]  s_tdata,   // [15:0] left_sample, [31:16] right_sample
    // output stream
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [2*SAMPLE_W-1:0]  m_tdata,   // [15:0] left_out, [31:16] right_out
    output logic                   m_tlast,   // last_of_run
    // configuration
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [APB_ADDR_W-1:0]  paddr,
    input  wire  [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int FB    = PHASE_FRACTION_BITS;
    localparam int PW    = FB + 5;
    localparam int SW    = ((PW > RATIO_W) ? PW : RATIO_W) + 1;
    localparam int CW    = (MAX_OUTPUTS_PER_INPUT > 1) ? $clog2(MAX_OUTPUTS_PER_INPUT) : 1;
    localparam logic [PW-1:0] PHASE_ONE = PW'(1) << FB;
    localparam logic [PW-1:0] PHASE_MAX = '1;
    localparam logic [CW-1:0] CNT_LAST  = CW'(MAX_OUTPUTS_PER_INPUT - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL_L = 4'b0010,
        ST_MUL_R = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state                     r_state;
    logic [RATIO_W-1:0]         r_ratio;
    logic                       r_stereo;
    logic                       r_primed;
    logic [PW-1:0]              r_phase;
    logic [CW-1:0]              r_count;
    logic signed [SAMPLE_W-1:0] r_prev_l, r_prev_r, r_cur_l, r_cur_r;
    logic signed [SAMPLE_W-1:0] r_left;
    logic                       r_m_valid, r_m_last;
    logic signed [SAMPLE_W-1:0] r_m_left, r_m_right;

    logic                       in_xfer, cfg_wr, lerp_en, out_load, is_last;
    logic signed [SAMPLE_W-1:0] in_l, in_r, mul_prev, mul_cur, lerp_res;
    logic [SW-1:0]              sum;
    logic [PW-1:0]              n_phase;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio  <= RATIO_RESET;
            r_stereo <= STEREO_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_RATIO:  r_ratio  <= pwdata[RATIO_W-1:0];
                REG_STEREO: r_stereo <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RATIO:  prdata = APB_DATA_W'(r_ratio);
            REG_STEREO: prdata = APB_DATA_W'(r_stereo);
            default:    prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    assign s_tready = (r_state == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign in_l     = s_tdata[SAMPLE_W-1:0];
    assign in_r     = r_stereo ? s_tdata[2*SAMPLE_W-1:SAMPLE_W] : '0;

    assign mul_prev = (r_state == ST_MUL_L) ? r_prev_l : r_prev_r;
    assign mul_cur  = (r_state == ST_MUL_L) ? r_cur_l  : r_cur_r;
    assign lerp_en  = (r_state == ST_MUL_L) || (r_state == ST_MUL_R);

    lirs_lerp_unit #(
        .FB (FB)
    ) u_lerp (
        .i_clk  (i_clk),
        .i_en   (lerp_en),
        .i_prev (mul_prev),
        .i_cur  (mul_cur),
        .i_frac (r_phase[FB-1:0]),
        .o_res  (lerp_res)
    );

    // saturating phase advance after each result
    assign sum      = SW'(r_phase) + SW'(r_ratio);
    assign n_phase  = (sum > SW'(PHASE_MAX)) ? PHASE_MAX : sum[PW-1:0];
    assign is_last  = (n_phase >= PHASE_ONE) || (r_count == CNT_LAST);
    assign out_load = (r_state == ST_EMIT) && (!r_m_valid || m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_primed <= 1'b0;
            r_phase  <= '0;
            r_count  <= '0;
            r_prev_l <= '0;
            r_prev_r <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_cur_l <= in_l;
                        r_cur_r <= in_r;
                        r_count <= '0;
                        if (!r_primed) begin
                            r_primed <= 1'b1;
                            r_prev_l <= in_l;
                            r_prev_r <= in_r;
                        end else if (r_phase >= PHASE_ONE) begin
                            // downsampling gap: no result from this frame
                            r_phase  <= r_phase - PHASE_ONE;
                            r_prev_l <= in_l;
                            r_prev_r <= in_r;
                        end else begin
                            r_state <= ST_MUL_L;
                        end
                    end
                end
                ST_MUL_L: r_state <= ST_MUL_R;
                ST_MUL_R: begin
                    r_left  <= lerp_res;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_load) begin
                        if (is_last) begin
                            r_phase  <= (n_phase >= PHASE_ONE) ? n_phase - PHASE_ONE : '0;
                            r_prev_l <= r_cur_l;
                            r_prev_r <= r_cur_r;
                            r_state  <= ST_IDLE;
                        end else begin
                            r_phase <= n_phase;
                            r_count <= r_count + CW'(1);
                            r_state <= ST_MUL_L;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_left  <= r_left;
            r_m_right <= r_stereo ? lerp_res : '0;
            r_m_last  <= is_last;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {r_m_right, r_m_left};
    assign m_tlast  = r_m_last;

    // ---------------- assertions ----------------
    `LIRS_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_LAST)
    `LIRS_ASSERT_NEXT(a_prime_only, i_clk, i_rst_n, in_xfer && !r_primed,
        r_primed && (r_state == ST_IDLE) && (r_phase == $past(r_phase)))
    `LIRS_ASSERT_NEXT(a_gap_drop, i_clk, i_rst_n, in_xfer && r_primed && (r_phase >= PHASE_ONE),
        (r_state == ST_IDLE) && (r_phase == $past(r_phase) - PHASE_ONE))
    `LIRS_ASSERT_NEXT(a_emit_next, i_clk, i_rst_n, out_load && !is_last,
        (r_state == ST_MUL_L) && r_m_valid && !r_m_last)

endmodule

`default_nettype wire
